// ----- rtl/core/ptu_pkg.sv -----
// Shared types, widths and constants of the path tracking error unit.
// Holds the CORDIC angle table and the status codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptu_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 38;      // CORDIC datapath width
    localparam int ZW           = 34;      // CORDIC angle accumulator width
    localparam logic signed [CW-1:0] KINV_Q30 = 38'sd652032874;

    localparam logic [1:0] ST_NO_PATH = 2'd0;
    localparam logic [1:0] ST_TRACK   = 2'd1;
    localparam logic [1:0] ST_GOAL    = 2'd2;
    localparam logic [1:0] ST_STOPPED = 2'd3;

    localparam logic CFG_GOAL_TOL = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [63:0]       dist_sq;
    } dist_res_t;

    function automatic logic [31:0] angle_step(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ptu_cordic.sv -----
// Iterative CORDIC, vectoring (atan2) or rotation (sin/cos), one step a cycle.
// Depends on ptu_pkg for widths and the angle table.
`timescale 1ns / 1ps
`default_nettype none
module ptu_cordic
    import ptu_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire                  vectoring,
    input  wire signed [CW-1:0]  x_in,
    input  wire signed [CW-1:0]  y_in,
    input  wire signed [ZW-1:0]  z_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    localparam logic signed [CW-1:0] LIM = 38'sd1073741824;

    logic [1:0]           state_reg;
    logic                 vec_reg;
    logic [STEP_W-1:0]    step_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 done_reg;

    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    logic                 rot_pos;

    always_comb
    begin
        xs      = x_reg >>> step_reg;
        ys      = y_reg >>> step_reg;
        a       = ZW'(angle_step(step_reg));
        rot_pos = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            vec_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        vec_reg  <= vectoring;
                        step_reg <= '0;
                        if (vectoring)
                        begin
                            // fold the left half plane onto the right one
                            if (x_in < 0)
                            begin
                                x_reg <= -x_in;
                                y_reg <= -y_in;
                                z_reg <= 34'sh080000000;
                            end
                            else
                            begin
                                x_reg <= x_in;
                                y_reg <= y_in;
                                z_reg <= '0;
                            end
                            state_reg <= C_NORM;
                        end
                        else
                        begin
                            x_reg     <= x_in;
                            y_reg     <= y_in;
                            z_reg     <= z_in;
                            state_reg <= C_ITER;
                        end
                    end
                end
                C_NORM:
                begin
                    if (x_reg < LIM && y_reg < LIM && y_reg > -LIM)
                    begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                    else
                        state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (rot_pos)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - a;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + a;
                    end
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_ITER |-> step_reg < STEP_W'(CORDIC_STEPS))
        else $error("cordic step out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == C_IDLE)
        else $error("cordic done while busy");
    a_norm_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_NORM |-> x_reg >= 0)
        else $error("cordic normalize with negative x");
endmodule
`default_nettype wire

// ----- rtl/core/ptu_dist_pipe.sv -----
// Three-stage squared-distance pipeline, one path point per cycle.
// Depends on ptu_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none
module ptu_dist_pipe
    import ptu_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire [ADDR_W-1:0]   in_idx,
    input  wire signed [31:0]  pt_x,
    input  wire signed [31:0]  pt_y,
    input  wire signed [31:0]  ref_x,
    input  wire signed [31:0]  ref_y,
    output dist_res_t          res,
    output logic               busy
);
    logic              v1_reg, v2_reg, v3_reg;
    logic [ADDR_W-1:0] i1_reg, i2_reg, i3_reg;
    logic [32:0]       ax_reg, ay_reg;
    logic [65:0]       sx_reg, sy_reg;
    logic [63:0]       d_reg;

    logic signed [32:0] dx, dy;
    logic [66:0]        sum;

    always_comb
    begin
        dx  = 33'(ref_x) - 33'(pt_x);
        dy  = 33'(ref_y) - 33'(pt_y);
        sum = 67'(sx_reg) + 67'(sy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg <= in_idx;
        ax_reg <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_reg <= dy[32] ? 33'(-dy) : 33'(dy);
        i2_reg <= i1_reg;
        sx_reg <= ax_reg * ax_reg;
        sy_reg <= ay_reg * ay_reg;
        i3_reg <= i2_reg;
        // saturate at 2^64-1
        d_reg  <= (sum[66:64] != 3'b000) ? {64{1'b1}} : sum[63:0];
    end

    assign res.valid   = v3_reg;
    assign res.idx     = i3_reg;
    assign res.dist_sq = d_reg;
    assign busy        = v1_reg | v2_reg | v3_reg;
endmodule
`default_nettype wire

// ----- rtl/core/path_tracking_error_unit.sv -----
// Path tracking error unit: path store, nearest-point search sequencer, errors.
// Depends on ptu_pkg, ptu_dist_pipe and ptu_cordic.
//
// Usage:
//  s_axis: one item a handshake. tuser selects load (0) or pose (1); tlast marks
//  the final point of a path load and commits the path. tdata carries pos_x,
//  pos_y and robot_yaw. A load item gives no result.
//  m_axis: one result per pose item: status, ref_index, ref_heading,
//  cross_track_error and heading_error packed in tdata.
//  cfg: index 0 goal radius, index 1 search window; always ready.
//  A pose with no path or with the block stopped goes straight to the output
//  stage, and so does one whose goal check hits; otherwise the search sends
//  one searched point per cycle (up to MAX_POINTS, 1024) through the distance
//  pipeline, after which the CORDIC atan2 (normalize plus 24 steps), the
//  sin/cos and the forming of the errors follow. The single memory read port
//  and the shared CORDIC make these steps run one after another.
//  s_axis_tready is low while a pose is worked.
//  Reset clears the path (no path), the tracking index and the goal flag and
//  loads the register defaults; the point store itself is not cleared.
//  A stalled receiver holds the result in the output register; the next pose
//  runs but waits to publish until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
module path_tracking_error_unit
    import ptu_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [79:0]  s_axis_tdata,   // pos_x[31:0], pos_y[63:32], robot_yaw[79:64]
    input  wire         s_axis_tuser,   // mode
    input  wire         s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status[1:0], ref_index[11:2], ref_heading[27:12],
                                        // cross_track_error[59:28], heading_error[75:60], 0
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire [23:0]  cfg_data
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GOAL_RD  = 4'd1;
    localparam logic [3:0] S_GOAL_WT  = 4'd2;
    localparam logic [3:0] S_SEARCH   = 4'd3;
    localparam logic [3:0] S_FET_REF  = 4'd4;
    localparam logic [3:0] S_FET_NB   = 4'd5;
    localparam logic [3:0] S_CAP_NB   = 4'd6;
    localparam logic [3:0] S_ATAN_GO  = 4'd7;
    localparam logic [3:0] S_ATAN_WT  = 4'd8;
    localparam logic [3:0] S_SC_GO    = 4'd9;
    localparam logic [3:0] S_SC_WT    = 4'd10;
    localparam logic [3:0] S_CT_MUL   = 4'd11;
    localparam logic [3:0] S_CT_SUM   = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    logic [3:0]        state_reg;
    logic [23:0]       goal_tol_reg;
    logic [10:0]       window_reg;
    logic [CNT_W-1:0]  point_cnt_reg, load_ptr_reg;
    logic [ADDR_W-1:0] track_reg;
    logic              path_valid_reg, goal_done_reg;

    logic [63:0]       mem [MAX_POINTS];
    logic [63:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    logic signed [31:0] px_reg, py_reg, rx_reg, ry_reg;
    logic signed [15:0] yaw_reg, head_reg;
    logic [47:0]        tol_sq_reg;
    logic               idx_ok_reg;
    logic [CNT_W-1:0]   scan_ptr_reg, scan_end_reg;
    logic [ADDR_W-1:0]  best_reg;
    logic [63:0]        best_d_reg;
    logic               found_reg;
    logic signed [32:0] vx_reg, vy_reg, ex_reg, ey_reg;
    logic               neg_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [65:0] p1_reg, p2_reg;

    logic [1:0]         r_status_reg;
    logic [ADDR_W-1:0]  r_idx_reg;
    logic signed [15:0] r_head_reg, r_he_reg;
    logic signed [31:0] r_cte_reg;
    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    logic               in_acc, wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               issue;
    logic [CNT_W-1:0]   load_next, last_idx, nb_addr_w, end_calc;
    logic [11:0]        win_sum;
    logic               has_next;
    logic [13:0]        idx10, n9;
    dist_res_t          dres;
    logic               pipe_busy;
    logic               c_start, c_vec, c_done;
    logic signed [CW-1:0] c_xin, c_yin, c_x, c_y;
    logic signed [ZW-1:0] c_zin, c_z, sc_z;
    logic               sc_neg;
    logic [31:0]        zr;
    logic signed [66:0] e_sum;
    logic signed [37:0] e_sh;
    logic signed [31:0] e_sat;
    logic signed [31:0] mem_x, mem_y;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = in_acc && !s_axis_tuser && (load_ptr_reg < CNT_W'(MAX_POINTS));
    assign load_next     = wr_en ? load_ptr_reg + 1'b1 : load_ptr_reg;
    assign last_idx      = point_cnt_reg - 1'b1;
    assign has_next      = (CNT_W'(best_reg) + 1'b1) < point_cnt_reg;
    assign nb_addr_w     = has_next ? CNT_W'(best_reg) + 1'b1 : CNT_W'(best_reg) - 1'b1;
    assign win_sum       = 12'(track_reg) + 12'(window_reg);
    assign end_calc      = (track_reg == '0) ? point_cnt_reg :
                           ((win_sum < 12'(point_cnt_reg)) ? CNT_W'(win_sum) : point_cnt_reg);
    assign idx10         = {1'b0, track_reg, 3'b000} + {3'b000, track_reg, 1'b0};
    assign n9            = {point_cnt_reg, 3'b000} + 14'(point_cnt_reg);
    assign mem_x         = rd_data_reg[31:0];
    assign mem_y         = rd_data_reg[63:32];

    always_comb
    begin
        issue   = 1'b0;
        rd_addr = scan_ptr_reg[ADDR_W-1:0];
        case (state_reg)
            S_GOAL_RD:
            begin
                issue   = 1'b1;
                rd_addr = last_idx[ADDR_W-1:0];
            end
            S_SEARCH:  issue = scan_ptr_reg < scan_end_reg;
            S_FET_REF: rd_addr = best_reg;
            S_FET_NB:  rd_addr = nb_addr_w[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[load_ptr_reg[ADDR_W-1:0]] <= {s_axis_tdata[63:32], s_axis_tdata[31:0]};
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    ptu_dist_pipe u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .pt_x     (mem_x),
        .pt_y     (mem_y),
        .ref_x    (px_reg),
        .ref_y    (py_reg),
        .res      (dres),
        .busy     (pipe_busy)
    );

    // sin/cos argument folded into +-pi/2
    always_comb
    begin
        sc_z   = ZW'({{2{head_reg[15]}}, head_reg, 16'h0000});
        sc_neg = 1'b0;
        if (sc_z > 34'sd1073741824)
        begin
            sc_z   = sc_z - 34'sd2147483648;
            sc_neg = 1'b1;
        end
        else if (sc_z < -34'sd1073741824)
        begin
            sc_z   = sc_z + 34'sd2147483648;
            sc_neg = 1'b1;
        end
    end

    assign c_vec   = (state_reg == S_ATAN_GO);
    assign c_start = (c_vec && !(vx_reg == '0 && vy_reg == '0)) || (state_reg == S_SC_GO);
    assign c_xin   = c_vec ? CW'(vx_reg) : KINV_Q30;
    assign c_yin   = c_vec ? CW'(vy_reg) : '0;
    assign c_zin   = sc_z;
    assign zr      = c_z[31:0] + 32'h8000;

    ptu_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (c_start),
        .vectoring (c_vec),
        .x_in      (c_xin),
        .y_in      (c_yin),
        .z_in      (c_zin),
        .done      (c_done),
        .x_out     (c_x),
        .y_out     (c_y),
        .z_out     (c_z)
    );

    always_comb
    begin
        e_sum = 67'(p1_reg >>> 1) + 67'(p2_reg >>> 1) + 67'sd268435456;
        e_sh  = 38'(e_sum >>> 29);
        if (e_sh > 38'sd2147483647)
            e_sat = 32'sh7FFFFFFF;
        else if (e_sh < -38'sd2147483648)
            e_sat = 32'sh80000000;
        else
            e_sat = e_sh[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            goal_tol_reg   <= 24'd19661;
            window_reg     <= 11'd100;
            point_cnt_reg  <= '0;
            load_ptr_reg   <= '0;
            track_reg      <= '0;
            path_valid_reg <= 1'b0;
            goal_done_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            scan_ptr_reg   <= '0;
            scan_end_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (issue && state_reg == S_SEARCH)
                scan_ptr_reg <= scan_ptr_reg + 1'b1;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GOAL_TOL: goal_tol_reg <= cfg_data;
                    CFG_WINDOW:   window_reg   <= cfg_data[10:0];
                endcase
            end

            // drop the taken result unless a new one is published this cycle
            if (m_valid_reg && m_axis_tready && state_reg != S_EMIT)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && !s_axis_tuser)
                    begin
                        if (s_axis_tlast)
                        begin
                            point_cnt_reg  <= load_next;
                            load_ptr_reg   <= '0;
                            track_reg      <= '0;
                            goal_done_reg  <= 1'b0;
                            path_valid_reg <= (load_next != '0);
                        end
                        else
                            load_ptr_reg <= load_next;
                    end
                    else if (in_acc)
                    begin
                        px_reg     <= s_axis_tdata[31:0];
                        py_reg     <= s_axis_tdata[63:32];
                        yaw_reg    <= s_axis_tdata[79:64];
                        tol_sq_reg <= goal_tol_reg * goal_tol_reg;
                        idx_ok_reg <= idx10 > n9;
                        r_idx_reg  <= '0;
                        r_head_reg <= '0;
                        r_cte_reg  <= '0;
                        r_he_reg   <= '0;
                        if (goal_done_reg)
                        begin
                            r_status_reg <= ST_STOPPED;
                            state_reg    <= S_EMIT;
                        end
                        else if (!path_valid_reg)
                        begin
                            r_status_reg <= ST_NO_PATH;
                            state_reg    <= S_EMIT;
                        end
                        else
                            state_reg <= S_GOAL_RD;
                    end
                end
                S_GOAL_RD: state_reg <= S_GOAL_WT;
                S_GOAL_WT:
                begin
                    if (dres.valid)
                    begin
                        if (dres.dist_sq < 64'(tol_sq_reg) && idx_ok_reg)
                        begin
                            goal_done_reg <= 1'b1;
                            r_status_reg  <= ST_GOAL;
                            state_reg     <= S_EMIT;
                        end
                        else
                        begin
                            scan_ptr_reg <= CNT_W'(track_reg);
                            scan_end_reg <= end_calc;
                            best_reg     <= track_reg;
                            found_reg    <= 1'b0;
                            state_reg    <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // earliest point wins on a tie
                    if (dres.valid && (!found_reg || dres.dist_sq < best_d_reg))
                    begin
                        best_d_reg <= dres.dist_sq;
                        best_reg   <= dres.idx;
                        found_reg  <= 1'b1;
                    end
                    else if (!issue && !rd_valid_reg && !pipe_busy)
                    begin
                        if (CNT_W'(best_reg) >= point_cnt_reg)
                        begin
                            best_reg  <= last_idx[ADDR_W-1:0];
                            track_reg <= last_idx[ADDR_W-1:0];
                        end
                        else
                            track_reg <= best_reg;
                        state_reg <= S_FET_REF;
                    end
                end
                S_FET_REF: state_reg <= S_FET_NB;
                S_FET_NB:
                begin
                    rx_reg    <= mem_x;
                    ry_reg    <= mem_y;
                    state_reg <= S_CAP_NB;
                end
                S_CAP_NB:
                begin
                    if (has_next)
                    begin
                        vx_reg <= 33'(mem_x) - 33'(rx_reg);
                        vy_reg <= 33'(mem_y) - 33'(ry_reg);
                    end
                    else if (best_reg != '0)
                    begin
                        vx_reg <= 33'(rx_reg) - 33'(mem_x);
                        vy_reg <= 33'(ry_reg) - 33'(mem_y);
                    end
                    else
                    begin
                        vx_reg <= '0;
                        vy_reg <= '0;
                    end
                    ex_reg    <= 33'(px_reg) - 33'(rx_reg);
                    ey_reg    <= 33'(py_reg) - 33'(ry_reg);
                    state_reg <= S_ATAN_GO;
                end
                S_ATAN_GO:
                begin
                    if (vx_reg == '0 && vy_reg == '0)
                    begin
                        head_reg  <= '0;
                        state_reg <= S_SC_GO;
                    end
                    else
                        state_reg <= S_ATAN_WT;
                end
                S_ATAN_WT:
                begin
                    if (c_done)
                    begin
                        head_reg  <= zr[31:16];
                        state_reg <= S_SC_GO;
                    end
                end
                S_SC_GO:
                begin
                    neg_reg   <= sc_neg;
                    state_reg <= S_SC_WT;
                end
                S_SC_WT:
                begin
                    if (c_done)
                    begin
                        cos_reg   <= neg_reg ? 32'(-c_x) : c_x[31:0];
                        sin_reg   <= neg_reg ? 32'(-c_y) : c_y[31:0];
                        state_reg <= S_CT_MUL;
                    end
                end
                S_CT_MUL:
                begin
                    p1_reg    <= -(66'(sin_reg) * 66'(ex_reg));
                    p2_reg    <= 66'(cos_reg) * 66'(ey_reg);
                    state_reg <= S_CT_SUM;
                end
                S_CT_SUM:
                begin
                    r_status_reg <= ST_TRACK;
                    r_idx_reg    <= best_reg;
                    r_head_reg   <= head_reg;
                    r_cte_reg    <= e_sat;
                    r_he_reg     <= yaw_reg - head_reg;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'h0, r_he_reg, r_cte_reg, r_head_reg,
                                        r_idx_reg, r_status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_track_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        path_valid_reg |-> CNT_W'(track_reg) < point_cnt_reg)
        else $error("tracking index beyond path");
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr_reg <= CNT_W'(MAX_POINTS))
        else $error("load pointer overflow");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> scan_ptr_reg <= scan_end_reg)
        else $error("scan pointer past window");
    a_goal_once: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(goal_done_reg) |-> r_status_reg == ST_GOAL)
        else $error("goal flag set without goal status");
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for path_tracking_error_unit: queued stimulus, a cycle driver,
// a result monitor and a bit-accurate predictor of path search, goal logic and CORDIC.
// Depends on ptu_pkg and the RTL of path_tracking_error_unit.
`timescale 1ns / 1ps
module testbench;
    import ptu_pkg::*;

    typedef enum int {J_ITEM, J_CFG, J_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t   kind;
        bit          mode;
        bit [31:0]   x;
        bit [31:0]   y;
        bit [15:0]   yaw;
        bit          last;
        bit          cfg_sel;
        bit [23:0]   cfg_val;
    } job_t;

    typedef struct {
        bit [1:0]  status;
        bit [9:0]  ref_index;
        bit [15:0] ref_heading;
        bit [31:0] cte;
        bit [15:0] heading_err;
    } track_res_t;

    localparam int TOL_MAX = 16777215;
    localparam int WIN_MAX = 1024;
    localparam longint LIM30 = 64'sd1073741824;

    localparam bit [31:0] ATAN_TAB [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [23:0] cfg_data = '0;

    path_tracking_error_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow state of the block
    int signed  path_x [0:MAX_POINTS-1];
    int signed  path_y [0:MAX_POINTS-1];
    int         point_cnt;
    int         load_ptr;
    int         track_idx;
    bit         path_ok;
    bit         goal_hit;
    longint     goal_tol;
    longint     window_len;

    job_t        job_q[$];
    track_res_t  pending_res[$];
    int          errors;
    int          results_seen;
    int          items_queued;

    // ---------------- predictor ----------------
    function automatic longint unsigned sq_dist(longint dx, longint dy);
        longint unsigned ax, ay, a, b;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        a = ax * ax;
        b = ay * ay;
        return (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
    endfunction

    function automatic bit [15:0] heading_of(longint x, longint y);
        bit [31:0] z;
        bit [31:0] rounded;
        longint xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        while (x < LIM30 && y < LIM30 && y > -LIM30)
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        rounded = z + 32'h8000;
        return rounded[31:16];
    endfunction

    task automatic rotate_unit(input bit [15:0] ang, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = longint'($signed(ang)) * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > LIM30)
        begin
            z = z - 2 * LIM30;
            flip = 1'b1;
        end
        else if (z < -LIM30)
        begin
            z = z + 2 * LIM30;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_item(input job_t j);
        track_res_t r;
        longint px, py, rx, ry, c, s, e;
        longint unsigned d, best_d;
        int last_i, stop_i, best;
        bit found;
        bit [15:0] head;
        if (!j.mode)
        begin
            if (load_ptr < MAX_POINTS)
            begin
                path_x[load_ptr] = j.x;
                path_y[load_ptr] = j.y;
                load_ptr++;
            end
            if (j.last)
            begin
                point_cnt = load_ptr;
                load_ptr = 0;
                track_idx = 0;
                goal_hit = 1'b0;
                path_ok = (point_cnt != 0);
            end
            return;
        end
        r = '{default: '0};
        px = longint'($signed(j.x));
        py = longint'($signed(j.y));
        if (goal_hit)
            r.status = ST_STOPPED;
        else if (!path_ok || point_cnt == 0)
            r.status = ST_NO_PATH;
        else if (sq_dist(px - path_x[point_cnt-1], py - path_y[point_cnt-1]) <
                 longint'(goal_tol) * goal_tol &&
                 longint'(track_idx) * 10 > longint'(point_cnt) * 9)
        begin
            goal_hit = 1'b1;
            r.status = ST_GOAL;
        end
        else
        begin
            stop_i = (track_idx == 0) ? point_cnt :
                     ((track_idx + window_len < point_cnt) ? track_idx + window_len : point_cnt);
            best = track_idx;
            best_d = 0;
            found = 1'b0;
            for (int i = track_idx; i < stop_i; i++)
            begin
                d = sq_dist(px - path_x[i], py - path_y[i]);
                if (!found || d < best_d)
                begin
                    best_d = d;
                    best = i;
                    found = 1'b1;
                end
            end
            if (best >= point_cnt)
                best = point_cnt - 1;
            track_idx = best;
            rx = path_x[best];
            ry = path_y[best];
            last_i = point_cnt - 1;
            if (best < last_i)
                head = heading_of(path_x[best+1] - rx, path_y[best+1] - ry);
            else if (best > 0)
                head = heading_of(rx - path_x[best-1], ry - path_y[best-1]);
            else
                head = 16'd0;
            rotate_unit(head, c, s);
            e = ((-s * (px - rx)) >>> 1) + ((c * (py - ry)) >>> 1);
            e = (e + (64'sd1 <<< 28)) >>> 29;
            if (e > 64'sd2147483647)
                e = 64'sd2147483647;
            if (e < -64'sd2147483648)
                e = -64'sd2147483648;
            r.status = ST_TRACK;
            r.ref_index = best[9:0];
            r.ref_heading = head;
            r.cte = e[31:0];
            r.heading_err = j.yaw - head;
        end
        pending_res.push_back(r);
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic add_load(input bit [31:0] x, input bit [31:0] y, input bit last);
        job_t j;
        j = '{kind: J_ITEM, mode: 1'b0, x: x, y: y, yaw: $urandom, last: last,
              cfg_sel: 1'b0, cfg_val: '0};
        job_q.push_back(j);
        items_queued++;
    endtask

    task automatic add_pose(input bit [31:0] x, input bit [31:0] y, input bit [15:0] yaw);
        job_t j;
        j = '{kind: J_ITEM, mode: 1'b1, x: x, y: y, yaw: yaw, last: $urandom_range(0, 1),
              cfg_sel: 1'b0, cfg_val: '0};
        job_q.push_back(j);
        items_queued++;
    endtask

    task automatic add_cfg(input bit sel, input bit [23:0] val);
        job_t j;
        j = '{kind: J_CFG, mode: 1'b0, x: '0, y: '0, yaw: '0, last: 1'b0,
              cfg_sel: sel, cfg_val: val};
        job_q.push_back(j);
    endtask

    task automatic add_drain();
        job_t j;
        j = '{kind: J_DRAIN, mode: 1'b0, x: '0, y: '0, yaw: '0, last: 1'b0,
              cfg_sel: 1'b0, cfg_val: '0};
        job_q.push_back(j);
    endtask

    // Load a random-walk path, then walk poses along it and park on the goal.
    task automatic add_route(input int n);
        int signed wx [$];
        int signed wy [$];
        int signed cx, cy, k, noise;
        cx = $signed($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        cy = $signed($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        for (int i = 0; i < n; i++)
        begin
            // repeat a point now and then so the heading source hits equal points
            if ($urandom_range(0, 15) != 0)
            begin
                cx = cx + $signed($urandom_range(0, 32'h40000)) - 32'h20000;
                cy = cy + $signed($urandom_range(0, 32'h40000)) - 32'h20000;
            end
            wx.push_back(cx);
            wy.push_back(cy);
            add_load(cx, cy, i == n - 1);
        end
        k = 0;
        noise = $urandom_range(0, 3) == 0 ? 60000 : 6000;
        while (k < n - 1)
        begin
            k = k + $urandom_range(0, 2);
            if (k > n - 1)
                k = n - 1;
            if ($urandom_range(0, 19) == 0)
                add_pose($urandom, $urandom, $urandom);
            else
                add_pose(wx[k] + $signed($urandom_range(0, 2 * noise)) - noise,
                         wy[k] + $signed($urandom_range(0, 2 * noise)) - noise, $urandom);
        end
        for (int i = 0; i < 3; i++)
            add_pose(wx[n-1] + $signed($urandom_range(0, 2000)) - 1000,
                     wy[n-1] + $signed($urandom_range(0, 2000)) - 1000, $urandom);
    endtask

    // ---------------- driver ----------------
    job_t cur_job;
    int   gap_left = 0;
    int   idle_cnt = 0;
    bit   no_gaps = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        bit nv, ncv;
        job_t j;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nv = s_axis_tvalid;
            ncv = cfg_valid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(cur_job);
                nv = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    no_gaps = !no_gaps;
                gap_left = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GOAL_TOL)
                    goal_tol = cfg_data;
                else
                    window_len = cfg_data[10:0];
                ncv = 1'b0;
            end
            if (pending_res.size() == 0 && !nv && !ncv)
                idle_cnt++;
            else
                idle_cnt = 0;
            if (!nv && !ncv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (job_q.size() > 0)
                begin
                    j = job_q[0];
                    if (j.kind == J_ITEM)
                    begin
                        void'(job_q.pop_front());
                        cur_job = j;
                        nv = 1'b1;
                        s_axis_tdata <= {j.yaw, j.y, j.x};
                        s_axis_tuser <= j.mode;
                        s_axis_tlast <= j.last;
                    end
                    else if (idle_cnt >= 40)
                    begin
                        // hold register writes and pauses until the block is quiet
                        void'(job_q.pop_front());
                        if (j.kind == J_CFG)
                        begin
                            ncv = 1'b1;
                            cfg_index <= j.cfg_sel;
                            cfg_data <= j.cfg_val;
                        end
                    end
                end
            end
            s_axis_tvalid <= nv;
            cfg_valid <= ncv;
        end
    end

    // ---------------- receiver and checker ----------------
    task automatic report_mismatch(input string what, input bit [31:0] got, input bit [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        track_res_t w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_res.size() == 0)
                begin
                    $display("unexpected result at %0t: 0x%0h", $realtime, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    w = pending_res.pop_front();
                    if (m_axis_tdata[1:0] !== w.status)
                        report_mismatch("status", m_axis_tdata[1:0], w.status);
                    if (m_axis_tdata[11:2] !== w.ref_index)
                        report_mismatch("ref_index", m_axis_tdata[11:2], w.ref_index);
                    if (m_axis_tdata[27:12] !== w.ref_heading)
                        report_mismatch("ref_heading", m_axis_tdata[27:12], w.ref_heading);
                    if (m_axis_tdata[59:28] !== w.cte)
                        report_mismatch("cross_track_error", m_axis_tdata[59:28], w.cte);
                    if (m_axis_tdata[75:60] !== w.heading_err)
                        report_mismatch("heading_error", m_axis_tdata[75:60], w.heading_err);
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 4);
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen >= 80)
            begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial
    begin
        int n;
        errors = 0;
        results_seen = 0;
        items_queued = 0;
        point_cnt = 0;
        load_ptr = 0;
        track_idx = 0;
        path_ok = 1'b0;
        goal_hit = 1'b0;
        goal_tol = 19661;
        window_len = 100;

        // directed: no path, single point, equal points, short path, goal and stop
        add_pose(32'h0, 32'h0, 16'h7FFF);
        add_load(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        add_load(32'd5, 32'd5, 1'b0);
        add_load(32'd5, 32'd5, 1'b1);
        add_pose(32'h0, 32'h0, 16'h0);
        add_load(32'd0, 32'd0, 1'b0);
        add_load(32'd65536, 32'd0, 1'b0);
        add_load(32'd65536, 32'd65536, 1'b1);
        add_pose(32'd65536, 32'd70000, 16'h4000);
        for (int i = 0; i < 11; i++)
            add_load(i * 65536, 32'd0, i == 10);
        add_pose(32'd327680, 32'd100, 16'h8000);
        add_pose(32'd655360, 32'hFFFF_FF00, 16'h0);
        add_pose(32'd655360, 32'd0, 16'h1234);
        add_pose(32'd655360, 32'd0, 16'h1234);

        add_cfg(CFG_GOAL_TOL, TOL_MAX);
        add_cfg(CFG_WINDOW, 1);
        add_route(12);
        add_cfg(CFG_GOAL_TOL, 0);
        add_cfg(CFG_WINDOW, WIN_MAX);
        add_route(15);
        add_cfg(CFG_GOAL_TOL, 19661);
        add_cfg(CFG_WINDOW, 100);

        while (items_queued < 540)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_load($urandom, $urandom, $urandom_range(0, 1));
                else
                    add_pose($urandom, $urandom, $urandom);
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(2, 25);
                add_route(n);
            end
            if (items_queued > 270 && items_queued < 300)
                add_drain();
            if ($urandom_range(0, 3) == 0)
            begin
                add_cfg(CFG_GOAL_TOL, ($urandom_range(0, 7) == 0) ? TOL_MAX
                                                                 : $urandom_range(0, 200000));
                add_cfg(CFG_WINDOW, ($urandom_range(0, 4) == 0) ? WIN_MAX
                                                               : $urandom_range(1, 64));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (job_q.size() > 0 || s_axis_tvalid || cfg_valid || pending_res.size() > 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
